// File: rtl/core/pcg_pkg.sv
package pcg_pkg;

  // Item commands
  localparam logic [1:0] CMD_URANGE = 2'd0;
  localparam logic [1:0] CMD_SRANGE = 2'd1;
  localparam logic [1:0] CMD_BYTES  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SEED_STATE = 1'b0;
  localparam logic CFG_SEED_SEQ   = 1'b1;

  // LCG multiplier
  localparam logic [63:0] PCG_MULT = 64'h5851_F42D_4C95_7F2D;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        bound;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
    logic [6:0]         byte_count;
  } pcg_in_t;

  typedef struct packed {
    logic [31:0]        value;
    logic signed [31:0] signed_value;
    logic [7:0]         byte_value;
    logic               error;
    logic               last;
  } pcg_out_t;

  // Controller to datapath
  typedef struct packed {
    logic cfg_write;
    logic item_load;
    logic seed_init;
    logic seed_add;
    logic draw_start;
    logic div_thr_start;
    logic div_res_start;
    logic res_take_draw;
    logic word_load;
    logic byte_adv;
    logic load_out;
  } pcg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] cmd_code;
    logic       range_err;
    logic       b_zero;
    logic       burst_zero;
    logic       byte_last;
    logic       byte_wrap;
    logic       below_thr;
    logic       draw_done;
    logic       div_done;
    logic       out_free;
  } pcg_sts_t;

  // XSH-RR output permutation of the pre-advance state
  function automatic logic [31:0] xsh_rr(input logic [63:0] s);
    logic [63:0] mix;
    logic [31:0] xs;
    logic [4:0]  rot;
    logic [63:0] dbl;
    mix = ((s >> 18) ^ s) >> 27;
    xs  = mix[31:0];
    rot = s[63:59];
    dbl = {xs, xs} >> rot;
    return dbl[31:0];
  endfunction

endpackage

// File: rtl/core/pcg_ctrl.sv
module pcg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  pcg_pkg::pcg_sts_t sts,
  output pcg_pkg::pcg_cmd_t cmd
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_SEED      = 5'd1;
  localparam logic [4:0] S_SEED_D1   = 5'd2;
  localparam logic [4:0] S_SEED_W1   = 5'd3;
  localparam logic [4:0] S_SEED_ADD  = 5'd4;
  localparam logic [4:0] S_SEED_D2   = 5'd5;
  localparam logic [4:0] S_SEED_W2   = 5'd6;
  localparam logic [4:0] S_DISPATCH  = 5'd7;
  localparam logic [4:0] S_RAW_DRAW  = 5'd8;
  localparam logic [4:0] S_RAW_WAIT  = 5'd9;
  localparam logic [4:0] S_THR_WAIT  = 5'd10;
  localparam logic [4:0] S_RNG_DRAW  = 5'd11;
  localparam logic [4:0] S_RNG_WAIT  = 5'd12;
  localparam logic [4:0] S_MOD_WAIT  = 5'd13;
  localparam logic [4:0] S_EMIT      = 5'd14;
  localparam logic [4:0] S_BYTE_DRAW = 5'd15;
  localparam logic [4:0] S_BYTE_WAIT = 5'd16;
  localparam logic [4:0] S_BYTE_EMIT = 5'd17;

  logic [4:0] state_r;
  logic [4:0] state_nxt;
  logic       idle;

  assign idle      = (state_r == S_IDLE);
  assign cfg_ready = idle;
  assign in_ready  = idle && !cfg_valid;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
          state_nxt     = S_SEED;
        end else if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_DISPATCH;
        end
      end
      S_SEED: begin
        cmd.seed_init = 1'b1;
        state_nxt     = S_SEED_D1;
      end
      S_SEED_D1: begin
        cmd.draw_start = 1'b1;
        state_nxt      = S_SEED_W1;
      end
      S_SEED_W1: begin
        if (sts.draw_done) state_nxt = S_SEED_ADD;
      end
      S_SEED_ADD: begin
        cmd.seed_add = 1'b1;
        state_nxt    = S_SEED_D2;
      end
      S_SEED_D2: begin
        cmd.draw_start = 1'b1;
        state_nxt      = S_SEED_W2;
      end
      S_SEED_W2: begin
        if (sts.draw_done) state_nxt = S_IDLE;
      end
      S_DISPATCH: begin
        priority if (sts.cmd_code == pcg_pkg::CMD_URANGE ||
                     sts.cmd_code == pcg_pkg::CMD_SRANGE) begin
          priority if (sts.range_err) begin
            state_nxt = S_EMIT;
          end else if (sts.b_zero) begin
            state_nxt = S_RAW_DRAW;
          end else begin
            cmd.div_thr_start = 1'b1;
            state_nxt         = S_THR_WAIT;
          end
        end else if (sts.cmd_code == pcg_pkg::CMD_BYTES) begin
          state_nxt = sts.burst_zero ? S_IDLE : S_BYTE_DRAW;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RAW_DRAW: begin
        cmd.draw_start = 1'b1;
        state_nxt      = S_RAW_WAIT;
      end
      S_RAW_WAIT: begin
        if (sts.draw_done) begin
          cmd.res_take_draw = 1'b1;
          state_nxt         = S_EMIT;
        end
      end
      S_THR_WAIT: begin
        if (sts.div_done) state_nxt = S_RNG_DRAW;
      end
      S_RNG_DRAW: begin
        cmd.draw_start = 1'b1;
        state_nxt      = S_RNG_WAIT;
      end
      S_RNG_WAIT: begin
        if (sts.draw_done) begin
          if (sts.below_thr) begin
            state_nxt = S_RNG_DRAW;
          end else begin
            cmd.div_res_start = 1'b1;
            state_nxt         = S_MOD_WAIT;
          end
        end
      end
      S_MOD_WAIT: begin
        if (sts.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_BYTE_DRAW: begin
        cmd.draw_start = 1'b1;
        state_nxt      = S_BYTE_WAIT;
      end
      S_BYTE_WAIT: begin
        if (sts.draw_done) begin
          cmd.word_load = 1'b1;
          state_nxt     = S_BYTE_EMIT;
        end
      end
      S_BYTE_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.byte_adv = 1'b1;
          priority if (sts.byte_last) state_nxt = S_IDLE;
          else if (sts.byte_wrap)     state_nxt = S_BYTE_DRAW;
          else                        state_nxt = S_BYTE_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SEED;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/pcg_dp.sv
module pcg_dp #(
  parameter int MAX_BURST = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pcg_pkg::pcg_in_t  in_data,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_data,
  input  pcg_pkg::pcg_cmd_t cmd,
  output pcg_pkg::pcg_sts_t sts,
  input  logic              out_ready,
  output logic              out_valid,
  output pcg_pkg::pcg_out_t out_data
);

  localparam logic [6:0]  MaxCnt  = 7'(MAX_BURST);
  localparam logic [31:0] MultLo  = pcg_pkg::PCG_MULT[31:0];
  localparam logic [31:0] MultHi  = pcg_pkg::PCG_MULT[63:32];
  localparam logic [5:0]  DivBits = 6'd32;

  // Seed registers and generator state
  logic [63:0] seed_state_r;
  logic [62:0] seed_seq_r;
  logic [63:0] gen_state_r;
  logic [63:0] gen_inc_r;

  // Item context
  logic [1:0]  cmd_r;
  logic [31:0] b_r;
  logic [31:0] lo_r;
  logic        err_r;
  logic [6:0]  n_r;
  logic [6:0]  k_r;
  logic [31:0] word_r;
  logic [31:0] thr_r;
  logic [31:0] result_r;

  // Draw unit: one shared 32x32 multiplier, three partial products
  logic [2:0]  mstep_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [31:0] draw_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  // Remainder unit: restoring, one bit per cycle
  logic [5:0]  dcnt_r;
  logic        div_thr_r;
  logic [31:0] num_r;
  logic [31:0] rem_r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic [31:0] rem_nxt;

  logic        out_valid_r;
  pcg_pkg::pcg_out_t out_r;
  pcg_pkg::pcg_out_t out_nxt;

  logic [6:0]  cnt_sat;
  logic        item_srange;

  always_comb begin
    unique case (mstep_r)
      3'd1:    begin mul_a = gen_state_r[63:32]; mul_b = MultLo; end
      3'd2:    begin mul_a = gen_state_r[31:0];  mul_b = MultHi; end
      default: begin mul_a = gen_state_r[31:0];  mul_b = MultLo; end
    endcase
  end

  assign trial   = {rem_r, num_r[31]};
  assign diff    = trial - {1'b0, b_r};
  assign rem_nxt = diff[32] ? trial[31:0] : diff[31:0];

  assign cnt_sat     = (in_data.byte_count > MaxCnt) ? MaxCnt : in_data.byte_count;
  assign item_srange = (in_data.command == pcg_pkg::CMD_SRANGE);

  // Seeding, state advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_state_r <= '0;
      seed_seq_r   <= '0;
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        pcg_pkg::CFG_SEED_STATE: seed_state_r <= cfg_data;
        pcg_pkg::CFG_SEED_SEQ:   seed_seq_r   <= cfg_data[62:0];
        default:                 seed_state_r <= seed_state_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_init) begin
      gen_state_r <= '0;
      gen_inc_r   <= {seed_seq_r, 1'b1};
    end else if (cmd.seed_add) begin
      gen_state_r <= gen_state_r + seed_state_r;
    end else if (mstep_r == 3'd4) begin
      gen_state_r <= acc_r + gen_inc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstep_r <= '0;
    end else if (cmd.draw_start) begin
      mstep_r <= 3'd1;
    end else if (mstep_r == 3'd4) begin
      mstep_r <= '0;
    end else if (mstep_r != 3'd0) begin
      mstep_r <= mstep_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_start) begin
      draw_r <= pcg_pkg::xsh_rr(gen_state_r);
    end
    if (cmd.draw_start || mstep_r == 3'd1 || mstep_r == 3'd2) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
    end
    unique case (mstep_r)
      3'd1:          acc_r <= prod_r;
      3'd2, 3'd3:    acc_r <= acc_r + {prod_r[31:0], 32'd0};
      default:       acc_r <= acc_r;
    endcase
  end

  // Remainder unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_thr_start || cmd.div_res_start) begin
      dcnt_r <= DivBits;
    end else if (dcnt_r != '0) begin
      dcnt_r <= dcnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_thr_start || cmd.div_res_start) begin
      num_r     <= cmd.div_thr_start ? (32'd0 - b_r) : draw_r;
      rem_r     <= '0;
      div_thr_r <= cmd.div_thr_start;
    end else if (dcnt_r != '0) begin
      num_r <= {num_r[30:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  // Item context, threshold, result, burst word
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      cmd_r <= in_data.command;
      lo_r  <= item_srange ? in_data.range_min : 32'd0;
      b_r   <= item_srange ? (in_data.range_max - in_data.range_min + 32'd1)
                           : in_data.bound;
      err_r <= item_srange && ($signed(in_data.range_max) < $signed(in_data.range_min));
      n_r   <= cnt_sat;
    end
    if (cmd.item_load) begin
      k_r <= '0;
    end else if (cmd.byte_adv) begin
      k_r <= k_r + 7'd1;
    end
    if (cmd.word_load) begin
      word_r <= draw_r;
    end else if (cmd.byte_adv) begin
      word_r <= word_r >> 8;
    end
    if (dcnt_r == 6'd1 && div_thr_r) begin
      thr_r <= rem_nxt;
    end
    if (dcnt_r == 6'd1 && !div_thr_r) begin
      result_r <= rem_nxt;
    end else if (cmd.res_take_draw) begin
      result_r <= draw_r;
    end
  end

  // Result assembly
  always_comb begin
    out_nxt      = '0;
    out_nxt.last = 1'b1;
    unique case (cmd_r)
      pcg_pkg::CMD_URANGE: out_nxt.value = result_r;
      pcg_pkg::CMD_SRANGE: begin
        if (err_r) out_nxt.error = 1'b1;
        else       out_nxt.signed_value = result_r + lo_r;
      end
      pcg_pkg::CMD_BYTES: begin
        out_nxt.byte_value = word_r[7:0];
        out_nxt.last       = sts.byte_last;
      end
      default: out_nxt.last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign sts.cmd_code   = cmd_r;
  assign sts.range_err  = err_r;
  assign sts.b_zero     = (b_r == 32'd0);
  assign sts.burst_zero = (n_r == 7'd0);
  assign sts.byte_last  = (k_r == n_r - 7'd1);
  assign sts.byte_wrap  = (k_r[1:0] == 2'b11);
  assign sts.below_thr  = (draw_r < thr_r);
  assign sts.draw_done  = (mstep_r == 3'd4);
  assign sts.div_done   = (dcnt_r == 6'd1);
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// File: rtl/core/pcg32_random_generator_core.sv
// PCG32 (XSH-RR) random generator with bounded-range, signed-range and byte-burst
// commands. After reset, and after every transfer on the cfg_ port, the block
// reseeds itself (state 0, step, add seed_state, step) and holds in_ready low
// meanwhile. For one draw the 64-bit state multiply runs as three partial
// products through a single shared 32x32 multiplier. A bounded draw also needs
// the rejection threshold (-bound mod bound) and the final remainder, each
// computed by a restoring remainder unit at one bit per cycle; a rejected draw
// is drawn again. A zero bound (or full signed span) returns a raw draw with no
// remainder pass, and an inverted signed range reports an error without a draw.
// A byte burst of n bytes draws one word per group of four bytes. Stalls on the
// result channel hold the block until the result register is free. Items are
// worked one at a time; the next item is taken while the last result of the
// previous one still waits in the output register.
module pcg32_random_generator_core #(
  parameter int MAX_BURST = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // item channel
  input  logic              in_valid,
  output logic              in_ready,
  input  pcg_pkg::pcg_in_t  in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output pcg_pkg::pcg_out_t out_data,
  // seed register writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_data
);

  pcg_pkg::pcg_cmd_t cmd;
  pcg_pkg::pcg_sts_t sts;

  // Sequence seeding, draws, remainder passes and result transfers
  pcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold seeds, generator state, multiplier, remainder unit and output register
  pcg_dp #(
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/pcg_chk.sv
module pcg_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input pcg_pkg::pcg_out_t out_data
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Reseeding follows reset, so no item is taken right after it
  a_seed_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("item taken before reseed");

  // An inverted range reports alone, with zeroed values, as the last result
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |->
      out_data.last && out_data.signed_value == 32'sd0 &&
      out_data.value == 32'd0 && out_data.byte_value == 8'd0)
    else $error("malformed range error result");

  // A burst byte carries no range result
  a_byte_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_value != 8'd0 |->
      out_data.value == 32'd0 && out_data.signed_value == 32'sd0 && !out_data.error)
    else $error("burst byte mixed with range result");

endmodule

bind pcg32_random_generator_core pcg_chk u_pcg_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
